### src/jddm_pkg.sv
// shared types and constants for the joystick differential drive mixer
package jddm_pkg;

    localparam int AXIS_W     = 8;
    localparam int DEADBAND_W = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [AXIS_W-1:0]     AXIS_CENTRE    = 8'd127;
    localparam logic [AXIS_W-1:0]     AXIS_TOP       = 8'd255;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 7'd10;
    localparam logic [AXIS_W-1:0]     FAILSAFE_RESET = 8'd255;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAILSAFE_TICKS = 2'd1;

    // item kinds on the input channel
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    typedef struct packed {
        logic              direction_level;
        logic [AXIS_W-1:0] duty_left;
        logic [AXIS_W-1:0] duty_right;
        logic              failsafe;
    } drive_t;

endpackage

### src/jddm_mix.sv
// stick packet to direction and two motor duties
module jddm_mix import jddm_pkg::*; (
    input  logic [AXIS_W-1:0]     speed_axis,
    input  logic [AXIS_W-1:0]     steer_axis,
    input  logic [DEADBAND_W-1:0] deadband,
    output drive_t                drive
);

    logic [AXIS_W-1:0]  speed_inv, steer_inv;
    logic [AXIS_W-1:0]  speed_dist, steer_dist;
    logic [AXIS_W-1:0]  s, t, t_adj;
    logic               fwd;
    logic [AXIS_W-1:0]  power;
    logic signed [9:0]  k3;
    logic signed [10:0] v_left, v_right;
    logic [AXIS_W-1:0]  d_left, d_right;

    function automatic logic [AXIS_W-1:0] clamp_half(input logic signed [10:0] v);
        logic [9:0] h;
        h = v[10:1];
        if (v[10])
            return '0;
        else if (h > 10'd255)
            return AXIS_TOP;
        else
            return h[AXIS_W-1:0];
    endfunction

    always_comb begin
        speed_inv = ~speed_axis;
        steer_inv = ~steer_axis;
        speed_dist = (speed_inv > AXIS_CENTRE) ? speed_inv - AXIS_CENTRE
                                               : AXIS_CENTRE - speed_inv;
        steer_dist = (steer_inv > AXIS_CENTRE) ? steer_inv - AXIS_CENTRE
                                               : AXIS_CENTRE - steer_inv;
        s = (speed_dist < {1'b0, deadband}) ? AXIS_CENTRE : speed_inv;
        t = (steer_dist < {1'b0, deadband}) ? AXIS_CENTRE : steer_inv;

        fwd   = s[7];
        // twice the distance from centre 127, or from 128 when forward, 0..254
        power = fwd ? {s[6:0], 1'b0} : {~s[6:0], 1'b0};

        t_adj = (t > AXIS_CENTRE) ? t - 8'd1 : t;
        k3    = 10'sd3 * ($signed({2'b00, t_adj}) - 10'sd127);

        v_left  = $signed({2'b00, power, 1'b0}) - {k3[9], k3};
        v_right = $signed({2'b00, power, 1'b0}) + {k3[9], k3};
        d_left  = clamp_half(v_left);
        d_right = clamp_half(v_right);

        drive.direction_level = ~fwd;
        drive.duty_left       = fwd ? d_left : ~d_left;
        drive.duty_right      = fwd ? d_right : ~d_right;
        drive.failsafe        = 1'b0;
    end

endmodule

### src/jddm_silence.sv
// silence counter that flags the stop drive after too many empty ticks
module jddm_silence import jddm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              operation,
    input  logic [AXIS_W-1:0] failsafe_ticks,
    output logic              stop_hit
);

    logic [AXIS_W-1:0] count_reg, count_next, count_inc;

    always_comb begin
        count_inc  = count_reg + 8'd1;
        count_next = count_reg;
        if (advance)
            count_next = (operation == OP_PACKET) ? '0 : count_inc;
        stop_hit = (operation == OP_TICK) && (count_inc == failsafe_ticks);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

### src/joystick_differential_drive_mixer.sv
// top level: input register, mixer and failsafe, result register
// an input transaction passes the input register and then the result register on its way to m_axis
// throughput: one packet or tick per cycle while the result slot is free or m_axis_tready is high
// ticks that do not bring the silence count up to the failsafe threshold give no result transaction
// synchronous active-low reset clears both stage valids, the silence counter
// and restores deadband 10 and failsafe threshold 255
module joystick_differential_drive_mixer import jddm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // speed_axis[7:0], steer_axis[15:8]
    input  logic [0:0]            s_axis_tuser,  // operation[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // direction_level[0], duty_left[8:1],
                                                 // duty_right[16:9], zero[23:17]
    output logic [0:0]            m_axis_tuser,  // failsafe[0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DEADBAND_W-1:0] deadband_reg;
    logic [AXIS_W-1:0]     failsafe_ticks_reg;

    logic              in_valid_reg;
    logic              op_reg;
    logic [AXIS_W-1:0] speed_reg, steer_reg;

    logic   out_valid_reg, out_valid_next;
    drive_t out_reg, out_next;

    logic   advance, stop_hit, emit;
    drive_t mixed, stop_drive;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg       <= DEADBAND_RESET;
            failsafe_ticks_reg <= FAILSAFE_RESET;
        end else if (cfg_valid) begin
            if (cfg_addr == CFG_DEADBAND)
                deadband_reg <= cfg_data[DEADBAND_W-1:0];
            else if (cfg_addr == CFG_FAILSAFE_TICKS)
                failsafe_ticks_reg <= cfg_data;
        end
    end

    // the held item moves on whenever the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg    <= s_axis_tuser[0];
            speed_reg <= s_axis_tdata[7:0];
            steer_reg <= s_axis_tdata[15:8];
        end
    end

    jddm_mix u_mix (
        .speed_axis (speed_reg),
        .steer_axis (steer_reg),
        .deadband   (deadband_reg),
        .drive      (mixed)
    );

    jddm_silence u_silence (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .operation      (op_reg),
        .failsafe_ticks (failsafe_ticks_reg),
        .stop_hit       (stop_hit)
    );

    always_comb begin
        stop_drive                 = '0;
        stop_drive.failsafe        = 1'b1;
        emit           = advance && ((op_reg == OP_PACKET) || stop_hit);
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_next       = (op_reg == OP_PACKET) ? mixed : stop_drive;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.duty_right, out_reg.duty_left,
                            out_reg.direction_level};
    assign m_axis_tuser  = out_reg.failsafe;

endmodule
